// ===== hw/rtl/power_bracket_command_table_core_defines.svh =====
// Assertion macros for the power bracket command table.
`ifndef POWER_BRACKET_COMMAND_TABLE_CORE_DEFINES_SVH
`define POWER_BRACKET_COMMAND_TABLE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PBCT_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("assertion failed");
`define PBCT_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("assertion failed");
`else
`define PBCT_ASSERT_IMP(lbl, ant, cons)
`define PBCT_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

// ===== hw/rtl/pbct_pkg.sv =====
`timescale 1ns / 1ps
package pbct_pkg;
    localparam int LEVELS_DEF = 8;
    localparam int CMDS_DEF   = 4;
    localparam int SLOT_W     = 6;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_MEAS  = 2'd1;
    localparam logic [1:0] ACT_INVAL = 2'd2;

    localparam logic [2:0] ST_CMD      = 3'd0;
    localparam logic [2:0] ST_NOCHANGE = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_ADDED    = 3'd3;
    localparam logic [2:0] ST_REPLACED = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_REJECTED = 3'd6;
    localparam logic [2:0] ST_INVAL    = 3'd7;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [63:0]       thr;
    } wr_t;

    typedef struct packed {
        logic [63:0]       key;
        logic              eq_hit;
        logic [SLOT_W-1:0] eq_slot;
        logic              ge_hit;
        logic [63:0]       ge_thr;
        logic [SLOT_W-1:0] ge_slot;
        logic [63:0]       max_thr;
        logic [SLOT_W-1:0] max_slot;
    } walk_t;
endpackage

// ===== hw/rtl/pbct_cell.sv =====
`timescale 1ns / 1ps
module pbct_cell #(
    parameter int LEVELS = pbct_pkg::LEVELS_DEF,
    parameter int CMDS   = pbct_pkg::CMDS_DEF,
    parameter int IDX    = 0,
    localparam int CW    = $clog2(LEVELS + 1)
) (
    input  logic                 aclk,
    input  logic [CW-1:0]        count,
    input  pbct_pkg::wr_t        wr,
    input  logic [31:0]          wr_cmds [CMDS],
    input  pbct_pkg::walk_t      walk_in,
    output pbct_pkg::walk_t      walk_out,
    output logic [31:0]          cmds [CMDS]
);
    logic [63:0] thr_reg;
    logic [31:0] cmd_reg [CMDS];
    pbct_pkg::walk_t walk_reg;
    pbct_pkg::walk_t walk_next;
    logic live;
    logic ge;

    always_ff @(posedge aclk) begin
        if (wr.en && wr.slot == pbct_pkg::SLOT_W'(IDX)) begin
            thr_reg <= wr.thr;
            cmd_reg <= wr_cmds;
        end
        walk_reg <= walk_next;
    end

    always_comb begin
        live = CW'(IDX) < count;
        ge = (walk_in.key != 64'd0) && (thr_reg >= walk_in.key);
        walk_next = walk_in;
        if (live) begin
            if (thr_reg == walk_in.key) begin
                walk_next.eq_hit  = 1'b1;
                walk_next.eq_slot = pbct_pkg::SLOT_W'(IDX);
            end
            if (ge && (!walk_in.ge_hit || thr_reg < walk_in.ge_thr)) begin
                walk_next.ge_hit  = 1'b1;
                walk_next.ge_thr  = thr_reg;
                walk_next.ge_slot = pbct_pkg::SLOT_W'(IDX);
            end
            // max_thr starts at zero, so the first live cell always seeds the max; thresholds are unique
            if (thr_reg >= walk_in.max_thr) begin
                walk_next.max_thr  = thr_reg;
                walk_next.max_slot = pbct_pkg::SLOT_W'(IDX);
            end
        end
    end

    assign walk_out = walk_reg;
    assign cmds     = cmd_reg;
endmodule

// ===== hw/rtl/power_bracket_command_table_core.sv =====
`timescale 1ns / 1ps
`include "power_bracket_command_table_core_defines.svh"
// Power bracket command table. Each of LEVELS cells holds one bracket (threshold
// and CMDS command words); a lookup record walks the chain of cells one cell per
// cycle. Adds and measures walk the whole chain before any result is handed out,
// while invalidate, rejected adds and measures on an empty table go straight to
// the response without a walk. One transaction is processed at a time; the next one is
// taken once the last result sits in the output register.
module power_bracket_command_table_core #(
    parameter int LEVELS = pbct_pkg::LEVELS_DEF,
    parameter int CMDS   = pbct_pkg::CMDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_threshold,
    input  logic [63:0] s_magnitude,
    input  logic [31:0] s_cmd_a,
    input  logic [31:0] s_cmd_b,
    input  logic [31:0] s_cmd_c,
    input  logic [31:0] s_cmd_d,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_bracket,
    output logic [31:0] m_command,
    output logic        m_last
);
    localparam int CW = $clog2(LEVELS + 1);
    localparam int SW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int KW = (CMDS > 1) ? $clog2(CMDS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_WALK, S_DECIDE, S_EMIT, S_RESP} state_t;

    state_t          state_reg;
    logic [SW-1:0]   cnt_reg;
    logic [1:0]      action_reg;
    logic [63:0]     key_reg;
    logic [31:0]     cmds_reg [CMDS];
    logic [31:0]     cut_cmds [CMDS];
    logic [CW-1:0]   count_reg;
    logic [SW-1:0]   act_reg;
    logic            act_valid_reg;
    logic [SW-1:0]   match_reg;
    logic [KW-1:0]   k_reg;
    logic [2:0]      res_status_reg;
    logic [SW-1:0]   res_slot_reg;
    pbct_pkg::wr_t   wr_reg;
    logic            m_valid_reg;
    logic [2:0]      m_status_reg;
    logic [2:0]      m_bracket_reg;
    logic [31:0]     m_command_reg;
    logic            m_last_reg;

    pbct_pkg::walk_t walk [LEVELS+1];
    logic [31:0]     cell_cmds [LEVELS][CMDS];
    pbct_pkg::walk_t tail;
    logic [SW-1:0]   match;
    logic            out_free;
    logic            accept;
    logic [31:0]     cur_word;
    logic            cur_last;

    always_comb begin
        logic [31:0] raw [4];
        logic ended;
        raw[0] = s_cmd_a;
        raw[1] = s_cmd_b;
        raw[2] = s_cmd_c;
        raw[3] = s_cmd_d;
        ended = 1'b0;
        for (int i = 0; i < CMDS; i++) begin
            if (i >= 4 || raw[i % 4] == 32'd0) begin
                ended = 1'b1;
            end
            cut_cmds[i] = ended ? 32'd0 : raw[i % 4];
        end
    end

    always_comb begin
        walk[0]          = '0;
        walk[0].key      = key_reg;
    end

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_cell
            pbct_cell #(.LEVELS(LEVELS), .CMDS(CMDS), .IDX(g)) u_cell (
                .aclk     (aclk),
                .count    (count_reg),
                .wr       (wr_reg),
                .wr_cmds  (cmds_reg),
                .walk_in  (walk[g]),
                .walk_out (walk[g+1]),
                .cmds     (cell_cmds[g])
            );
        end
    endgenerate

    assign tail     = walk[LEVELS];
    assign match    = tail.ge_hit ? SW'(tail.ge_slot) : SW'(tail.max_slot);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign cur_word = cell_cmds[match_reg][k_reg];

    always_comb begin
        if (k_reg == KW'(CMDS - 1)) begin
            cur_last = 1'b1;
        end else begin
            cur_last = (cell_cmds[match_reg][k_reg + KW'(1)] == 32'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            act_valid_reg <= 1'b0;
            act_reg       <= '0;
            m_valid_reg   <= 1'b0;
            wr_reg.en     <= 1'b0;
        end else begin
            wr_reg.en <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        action_reg <= s_action;
                        key_reg    <= (s_action == pbct_pkg::ACT_ADD) ? s_threshold
                                                                      : s_magnitude;
                        cmds_reg   <= cut_cmds;
                        cnt_reg    <= '0;
                        res_slot_reg <= '0;
                        case (s_action)
                            pbct_pkg::ACT_ADD: begin
                                if (s_cmd_a == 32'd0) begin
                                    res_status_reg <= pbct_pkg::ST_REJECTED;
                                    state_reg      <= S_RESP;
                                end else begin
                                    state_reg <= S_WALK;
                                end
                            end
                            pbct_pkg::ACT_MEAS: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= pbct_pkg::ST_EMPTY;
                                    state_reg      <= S_RESP;
                                end else begin
                                    state_reg <= S_WALK;
                                end
                            end
                            pbct_pkg::ACT_INVAL: begin
                                act_valid_reg  <= 1'b0;
                                act_reg        <= '0;
                                res_status_reg <= pbct_pkg::ST_INVAL;
                                state_reg      <= S_RESP;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_WALK: begin
                    // advance until the record leaves the last cell
                    cnt_reg <= cnt_reg + SW'(1);
                    if (cnt_reg == SW'(LEVELS - 1)) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (action_reg == pbct_pkg::ACT_ADD) begin
                        wr_reg.thr <= key_reg;
                        if (tail.eq_hit) begin
                            wr_reg.en      <= 1'b1;
                            wr_reg.slot    <= tail.eq_slot;
                            res_status_reg <= pbct_pkg::ST_REPLACED;
                            res_slot_reg   <= SW'(tail.eq_slot);
                        end else if (count_reg == CW'(LEVELS)) begin
                            res_status_reg <= pbct_pkg::ST_FULL;
                        end else begin
                            wr_reg.en      <= 1'b1;
                            wr_reg.slot    <= pbct_pkg::SLOT_W'(count_reg);
                            count_reg      <= count_reg + CW'(1);
                            res_status_reg <= pbct_pkg::ST_ADDED;
                            res_slot_reg   <= SW'(count_reg);
                        end
                        state_reg <= S_RESP;
                    end else if (act_valid_reg && act_reg == match) begin
                        res_status_reg <= pbct_pkg::ST_NOCHANGE;
                        res_slot_reg   <= match;
                        state_reg      <= S_RESP;
                    end else begin
                        act_reg       <= match;
                        act_valid_reg <= 1'b1;
                        match_reg     <= match;
                        k_reg         <= '0;
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= pbct_pkg::ST_CMD;
                        m_bracket_reg <= 3'(match_reg);
                        m_command_reg <= cur_word;
                        m_last_reg    <= cur_last;
                        k_reg         <= k_reg + KW'(1);
                        if (cur_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= res_status_reg;
                        m_bracket_reg <= 3'(res_slot_reg);
                        m_command_reg <= 32'd0;
                        m_last_reg    <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_bracket = m_bracket_reg;
    assign m_command = m_command_reg;
    assign m_last    = m_last_reg;

    `PBCT_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(LEVELS))
    `PBCT_ASSERT_IMP(a_active_live, act_valid_reg, CW'(act_reg) < count_reg)
    `PBCT_ASSERT_IMP(a_cmd_nonzero, m_valid && m_status == pbct_pkg::ST_CMD, m_command != 32'd0)
    `PBCT_ASSERT_NXT(a_write_grows, wr_reg.en && res_status_reg == pbct_pkg::ST_ADDED, count_reg != '0)
endmodule

// ===== test/power_bracket_command_table_core_tb.sv =====
`timescale 1ns / 1ps
module power_bracket_command_table_core_tb;

    localparam int NLEV = 8;
    localparam int NCMD = 4;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] threshold;
        logic [63:0] magnitude;
        logic [31:0] cmd [4];
        bit          pause;
    } power_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [2:0]  bracket;
        logic [31:0] command;
        logic        last;
    } table_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [63:0] s_threshold = '0;
    logic [63:0] s_magnitude = '0;
    logic [31:0] s_cmd_a = '0;
    logic [31:0] s_cmd_b = '0;
    logic [31:0] s_cmd_c = '0;
    logic [31:0] s_cmd_d = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [2:0]  m_bracket;
    logic [31:0] m_command;
    logic        m_last;

    power_bracket_command_table_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_threshold(s_threshold), .s_magnitude(s_magnitude),
        .s_cmd_a(s_cmd_a), .s_cmd_b(s_cmd_b), .s_cmd_c(s_cmd_c), .s_cmd_d(s_cmd_d),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_bracket(m_bracket), .m_command(m_command), .m_last(m_last)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [63:0] thr_tab [NLEV];
    logic [31:0] cmd_tab [NLEV][NCMD];
    int          order_tab [NLEV];
    int          n_entries;
    int          active_slot;
    bit          active_ok;

    power_req_t  pending_reqs [$];
    table_resp_t expected_resps [$];
    int          mismatches = 0;
    bit          stim_done = 0;
    bit          hold_sink = 0;
    bit          all_sent = 0;
    int          idle_cycles = 0;

    function automatic void push_resp(logic [2:0] st, int slot, logic [31:0] w, logic l);
        table_resp_t r;
        r.status = st;
        r.bracket = slot[2:0];
        r.command = w;
        r.last = l;
        expected_resps.push_back(r);
    endfunction

    function automatic void resort_table();
        int j;
        int s;
        for (int i = 0; i < n_entries; i++) begin
            s = i;
            j = i;
            while (j > 0 && thr_tab[order_tab[j-1]] > thr_tab[s]) begin
                order_tab[j] = order_tab[j-1];
                j--;
            end
            order_tab[j] = s;
        end
    endfunction

    function automatic void predict_table(power_req_t q);
        int slot;
        int n;
        bit hit;
        bit ended;
        logic [63:0] prev;
        slot = 0;
        hit = 0;
        if (q.action == pbct_pkg::ACT_ADD) begin
            if (q.cmd[0] == 0) begin
                push_resp(pbct_pkg::ST_REJECTED, 0, 0, 1);
                return;
            end
            for (int i = 0; i < n_entries; i++) begin
                if (!hit && thr_tab[i] == q.threshold) begin
                    slot = i;
                    hit = 1;
                end
            end
            if (!hit && n_entries >= NLEV) begin
                push_resp(pbct_pkg::ST_FULL, 0, 0, 1);
                return;
            end
            if (!hit) slot = n_entries;
            thr_tab[slot] = q.threshold;
            ended = 0;
            for (int i = 0; i < NCMD; i++) begin
                if (q.cmd[i] == 0) ended = 1;
                cmd_tab[slot][i] = ended ? 32'd0 : q.cmd[i];
            end
            if (!hit) n_entries++;
            resort_table();
            push_resp(hit ? pbct_pkg::ST_REPLACED : pbct_pkg::ST_ADDED, slot, 0, 1);
        end else if (q.action == pbct_pkg::ACT_MEAS) begin
            if (n_entries == 0) begin
                push_resp(pbct_pkg::ST_EMPTY, 0, 0, 1);
                return;
            end
            prev = 0;
            for (int i = 0; i < n_entries; i++) begin
                if (!hit) begin
                    if (prev < q.magnitude && q.magnitude <= thr_tab[order_tab[i]]) begin
                        slot = order_tab[i];
                        hit = 1;
                    end
                    prev = thr_tab[order_tab[i]];
                end
            end
            if (!hit) slot = order_tab[n_entries-1];
            if (active_ok && active_slot == slot) begin
                push_resp(pbct_pkg::ST_NOCHANGE, slot, 0, 1);
                return;
            end
            n = 0;
            while (n < NCMD && cmd_tab[slot][n] != 0) n++;
            for (int i = 0; i < n; i++)
                push_resp(pbct_pkg::ST_CMD, slot, cmd_tab[slot][i], i == n - 1);
            active_slot = slot;
            active_ok = 1;
        end else if (q.action == pbct_pkg::ACT_INVAL) begin
            active_ok = 0;
            push_resp(pbct_pkg::ST_INVAL, 0, 0, 1);
        end
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // driver
    int send_gap = 0;
    bit wait_drain = 0;
    power_req_t cur_req;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_table(cur_req);
                wait_drain <= cur_req.pause;
            end
            if (s_valid && !s_ready) begin
                // hold until accepted
            end else if (wait_drain && !(s_valid && s_ready)
                         && expected_resps.size() != 0) begin
                s_valid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && !(wait_drain
                         && expected_resps.size() != 0) && !(s_valid && s_ready
                         && cur_req.pause)) begin
                cur_req = pending_reqs.pop_front();
                s_action <= cur_req.action;
                s_threshold <= cur_req.threshold;
                s_magnitude <= cur_req.magnitude;
                s_cmd_a <= cur_req.cmd[0];
                s_cmd_b <= cur_req.cmd[1];
                s_cmd_c <= cur_req.cmd[2];
                s_cmd_d <= cur_req.cmd[3];
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
                if (stim_done && pending_reqs.size() == 0) all_sent <= 1;
            end
        end
    end

    // monitor and result sink
    int sink_gap = 0;
    table_resp_t exp_r;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result st=%0d br=%0d cmd=%h last=%0d",
                                 m_status, m_bracket, m_command, m_last);
                end else begin
                    exp_r = expected_resps.pop_front();
                    if (m_status !== exp_r.status || m_bracket !== exp_r.bracket ||
                        m_command !== exp_r.command || m_last !== exp_r.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp st=%0d br=%0d cmd=%h last=%0d got st=%0d br=%0d cmd=%h last=%0d",
                                     exp_r.status, exp_r.bracket, exp_r.command, exp_r.last,
                                     m_status, m_bracket, m_command, m_last);
                    end
                end
            end
            if (hold_sink) begin
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                sink_gap <= pick_gap();
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // long receiver hold-off, counted in its own process
    initial begin
        wait (aresetn);
        repeat (400) @(posedge aclk);
        hold_sink = 1;
        repeat (300) @(posedge aclk);
        hold_sink = 0;
    end

    logic [63:0] used_thr [$];

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] rand_word();
        return ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom();
    endfunction

    function automatic void queue_req(logic [1:0] a, logic [63:0] t, logic [63:0] m,
                                      logic [31:0] c0, logic [31:0] c1,
                                      logic [31:0] c2, logic [31:0] c3, bit p);
        power_req_t q;
        q.action = a;
        q.threshold = t;
        q.magnitude = m;
        q.cmd[0] = c0;
        q.cmd[1] = c1;
        q.cmd[2] = c2;
        q.cmd[3] = c3;
        q.pause = p;
        pending_reqs.push_back(q);
    endfunction

    function automatic logic [63:0] pick_mag();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 0;
        if (k == 1) return '1;
        if (k < 6 && used_thr.size() != 0) begin
            return used_thr[$urandom_range(0, used_thr.size() - 1)]
                   + 64'($signed($urandom_range(0, 2)) - 1);
        end
        return rand64();
    endfunction

    initial begin
        int k;
        logic [63:0] t;
        // directed part
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd5, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_ADD, 64'd100, 0, 0, 32'h1, 32'h2, 32'h3, 0);
        queue_req(pbct_pkg::ACT_ADD, 64'd100, 0, 32'hffffffff, 32'h2, 0, 32'h9, 0);
        queue_req(pbct_pkg::ACT_ADD, '1, 0, 32'h11, 32'h12, 32'h13, 32'h14, 0);
        queue_req(pbct_pkg::ACT_ADD, 64'd0, 0, 32'h21, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_ADD, 64'd1000, 0, 32'haaaaaaaa, 32'h55555555,
                  32'hffffffff, 32'h1, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd0, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd0, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd50, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd100, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd101, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_ADD, 64'd1000, 0, 32'h77, 32'h78, 0, 0, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd999, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_INVAL, 0, 0, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd999, 0, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_MEAS, 0, '1, 0, 0, 0, 0, 0);
        queue_req(2'd3, '1, '1, '1, '1, '1, '1, 0);
        for (int i = 0; i < 4; i++)
            queue_req(pbct_pkg::ACT_ADD, 64'd200 + i, 0, 32'h100 + i, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_ADD, 64'd7777, 0, 32'h5, 0, 0, 0, 0);
        queue_req(pbct_pkg::ACT_ADD, 64'd0, 0, 32'h22, 32'h23, 0, 0, 1);
        queue_req(pbct_pkg::ACT_MEAS, 0, 64'd202, 0, 0, 0, 0, 0);
        // random part: a fresh set of thresholds each round, with adds, measures and other actions mixed at random
        while (pending_reqs.size() < 300) begin
            used_thr.delete();
            for (int i = 0; i < 8; i++) used_thr.push_back(rand64() >> $urandom_range(0, 60));
            repeat ($urandom_range(4, 14)) begin
                k = $urandom_range(0, 19);
                t = used_thr[$urandom_range(0, 7)];
                if (k < 8)
                    queue_req(pbct_pkg::ACT_ADD, t, rand64(), rand_word(), rand_word(),
                              rand_word(), rand_word(), 0);
                else if (k < 17)
                    queue_req(pbct_pkg::ACT_MEAS, rand64(), pick_mag(), $urandom(),
                              $urandom(), $urandom(), $urandom(), 0);
                else if (k < 19)
                    queue_req(pbct_pkg::ACT_INVAL, rand64(), rand64(), $urandom(),
                              $urandom(), $urandom(), $urandom(), 0);
                else
                    queue_req(2'($urandom_range(0, 3)), rand64(), rand64(), $urandom(),
                              $urandom(), $urandom(), $urandom(), 0);
            end
        end
        pending_reqs[pending_reqs.size() / 2].pause = 1;
        stim_done = 1;
    end

    initial begin
        active_ok = 0;
        active_slot = 0;
        n_entries = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait ((all_sent && !s_valid && expected_resps.size() == 0)
              || idle_cycles >= STALL_LIMIT);
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
        end else begin
            repeat (50) @(posedge aclk);
            if (mismatches == 0 && expected_resps.size() == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("CHECKS FAILED");
            end
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pbct_pkg.sv
hw/rtl/pbct_cell.sv
hw/rtl/power_bracket_command_table_core.sv
test/power_bracket_command_table_core_tb.sv
